// ----- src/dpia_pkg.sv -----
// Package for the dual peripheral adapter register block.
// Holds request codes, register offsets and the structs shared by the modules.
// Depends on nothing.
`default_nettype none

package dpia_pkg;

    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 56;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 1;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_HSYNC = 2'd2,
        REQ_VSYNC = 2'd3
    } req_kind_t;

    localparam logic [1:0] EDGE_FALL = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_ANY  = 2'd2;

    localparam logic [1:0] OFS_ADATA = 2'd0;
    localparam logic [1:0] OFS_ACTRL = 2'd1;
    localparam logic [1:0] OFS_BDATA = 2'd2;
    localparam logic [1:0] OFS_BCTRL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LOAD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CART_INSERTED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CART_AUTOSTART = 2'd2;

    localparam logic [7:0] CTRL_KEEP = 8'h3F;
    localparam logic [7:0] FLAG_HIGH = 8'h80;

    typedef struct packed {
        req_kind_t   req_type;
        logic [2:0]  addr;
        logic [7:0]  wdata;
        logic [1:0]  edge_req;
        logic [7:0]  key_pins;
        logic        cassette_in;
    } req_t;

    typedef struct packed {
        logic fast_load;
        logic cart_inserted;
        logic cart_autostart;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       hsync_irq;
        logic       vsync_irq;
        logic       cart_firq;
        logic [7:0] column_drive;
        logic [1:0] mux_select;
        logic       motor_on;
        logic [4:0] video_mode;
        logic [6:0] audio_dac;
        logic [7:0] cassette_out;
        logic [7:0] sound_level;
        logic       printer_bit;
    } res_t;

endpackage

`default_nettype wire

// ----- src/dpia_in_stage.sv -----
// Input register for request words.
// Unpacks tdata/tuser into a request struct; uses dpia_pkg.
`default_nettype none

module dpia_in_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dpia_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [dpia_pkg::S_USER_W-1:0] s_tuser,
    input  wire logic                          out_free,
    output logic                               adv,
    output dpia_pkg::req_t                     req
);
    import dpia_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    req_t req_in;

    assign adv      = valid_reg && out_free;
    assign s_tready = !valid_reg || adv;
    assign req      = req_reg;

    always_comb
    begin
        req_in.req_type    = req_kind_t'(s_tuser[1:0]);
        req_in.addr        = s_tdata[2:0];
        req_in.wdata       = s_tdata[10:3];
        req_in.edge_req    = s_tdata[12:11];
        req_in.key_pins    = s_tdata[20:13];
        req_in.cassette_in = s_tdata[21];
        valid_next         = (s_tvalid && s_tready) || (valid_reg && !adv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= req_in;
        end
    end

endmodule

`default_nettype wire

// ----- src/dpia_core.sv -----
// Adapter register state and its single-pass update per request.
// Produces the result fields from the updated state; uses dpia_pkg.
`default_nettype none

module dpia_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire dpia_pkg::req_t req,
    input  wire dpia_pkg::cfg_t cfg,
    output dpia_pkg::res_t res
);
    import dpia_pkg::*;

    logic [7:0] first_regs_reg [4];
    logic [7:0] first_regs_next [4];
    logic [7:0] first_dirs_reg [2];
    logic [7:0] first_dirs_next [2];
    logic [7:0] second_regs_reg [4];
    logic [7:0] second_regs_next [4];
    logic [7:0] second_dirs_reg [2];
    logic [7:0] second_dirs_next [2];
    logic [6:0] dac_level_reg;
    logic [6:0] dac_level_next;
    logic [7:0] tape_level_reg;
    logic [7:0] tape_level_next;
    logic       beep_bit_reg;
    logic       beep_bit_next;
    logic [2:0] irq_lines_reg;
    logic [2:0] irq_lines_next;

    logic [7:0] rd;
    logic [1:0] off;
    logic [1:0] mux_cur;
    logic [7:0] bdata;
    logic       hit;

    always_comb
    begin
        first_regs_next  = first_regs_reg;
        first_dirs_next  = first_dirs_reg;
        second_regs_next = second_regs_reg;
        second_dirs_next = second_dirs_reg;
        dac_level_next   = dac_level_reg;
        tape_level_next  = tape_level_reg;
        beep_bit_next    = beep_bit_reg;
        irq_lines_next   = irq_lines_reg;
        rd      = 8'h00;
        hit     = 1'b0;
        bdata   = req.wdata & second_dirs_reg[1];
        off     = req.addr[1:0];
        mux_cur = {first_regs_reg[OFS_BCTRL][3], first_regs_reg[OFS_ACTRL][3]};

        case (req.req_type)
            REQ_READ:
            begin
                if (!req.addr[2])
                begin
                    case (off)
                        OFS_ADATA:
                        begin
                            if (!first_regs_reg[OFS_ACTRL][2])
                            begin
                                rd = first_dirs_reg[0];
                            end
                            else
                            begin
                                first_regs_next[OFS_ACTRL] = first_regs_reg[OFS_ACTRL] & CTRL_KEEP;
                                irq_lines_next[0] = 1'b0;
                                rd = req.key_pins;
                            end
                        end
                        OFS_BDATA:
                        begin
                            if (!first_regs_reg[OFS_BCTRL][2])
                            begin
                                rd = first_dirs_reg[1];
                            end
                            else
                            begin
                                first_regs_next[OFS_BCTRL] = first_regs_reg[OFS_BCTRL] & CTRL_KEEP;
                                irq_lines_next[1] = 1'b0;
                                rd = first_regs_reg[OFS_BDATA] & first_dirs_reg[1];
                            end
                        end
                        default:
                        begin
                            rd = first_regs_reg[off];
                        end
                    endcase
                end
                else
                begin
                    case (off)
                        OFS_ADATA:
                        begin
                            if (!second_regs_reg[OFS_ACTRL][2])
                            begin
                                rd = second_dirs_reg[0];
                            end
                            else
                            begin
                                second_regs_next[OFS_ACTRL] =
                                    second_regs_reg[OFS_ACTRL] & CTRL_KEEP;
                                rd = second_regs_reg[OFS_ADATA];
                                if (cfg.fast_load)
                                begin
                                    rd[0] = req.cassette_in;
                                end
                            end
                        end
                        OFS_BDATA:
                        begin
                            if (!second_regs_reg[OFS_BCTRL][2])
                            begin
                                rd = second_dirs_reg[1];
                            end
                            else
                            begin
                                second_regs_next[OFS_BCTRL] =
                                    second_regs_reg[OFS_BCTRL] & CTRL_KEEP;
                                irq_lines_next[2] = 1'b0;
                                rd = second_regs_reg[OFS_BDATA] & second_dirs_reg[1];
                            end
                        end
                        default:
                        begin
                            rd = second_regs_reg[off];
                        end
                    endcase
                end
            end
            REQ_WRITE:
            begin
                if (!req.addr[2])
                begin
                    case (off)
                        OFS_ADATA:
                        begin
                            if (first_regs_reg[OFS_ACTRL][2])
                            begin
                                first_regs_next[OFS_ADATA] = req.wdata;
                            end
                            else
                            begin
                                first_dirs_next[0] = req.wdata;
                            end
                        end
                        OFS_BDATA:
                        begin
                            if (first_regs_reg[OFS_BCTRL][2])
                            begin
                                first_regs_next[OFS_BDATA] = req.wdata;
                            end
                            else
                            begin
                                first_dirs_next[1] = req.wdata;
                            end
                        end
                        default:
                        begin
                            first_regs_next[off] = req.wdata & CTRL_KEEP;
                        end
                    endcase
                end
                else
                begin
                    case (off)
                        OFS_ADATA:
                        begin
                            if (second_regs_reg[OFS_ACTRL][2])
                            begin
                                second_regs_next[OFS_ADATA] = req.wdata;
                                if (mux_cur == 2'd0)
                                begin
                                    if (second_regs_reg[OFS_BCTRL][3])
                                    begin
                                        dac_level_next = {req.wdata[7:2], 1'b0};
                                    end
                                    else
                                    begin
                                        tape_level_next = {req.wdata[7:2], 2'b00};
                                    end
                                end
                            end
                            else
                            begin
                                second_dirs_next[0] = req.wdata;
                            end
                        end
                        OFS_BDATA:
                        begin
                            if (second_regs_reg[OFS_BCTRL][2])
                            begin
                                second_regs_next[OFS_BDATA] = bdata;
                                beep_bit_next = bdata[1];
                            end
                            else
                            begin
                                second_dirs_next[1] = req.wdata;
                            end
                        end
                        default:
                        begin
                            second_regs_next[off] = req.wdata & CTRL_KEEP;
                        end
                    endcase
                end
            end
            REQ_HSYNC:
            begin
                hit = (req.edge_req == EDGE_ANY)
                    || (req.edge_req == EDGE_FALL && !first_regs_reg[OFS_ACTRL][1])
                    || (req.edge_req == EDGE_RISE && first_regs_reg[OFS_ACTRL][1]);
                if (hit)
                begin
                    first_regs_next[OFS_ACTRL] = first_regs_reg[OFS_ACTRL] | FLAG_HIGH;
                    if (first_regs_reg[OFS_ACTRL][0])
                    begin
                        irq_lines_next[0] = 1'b1;
                    end
                end
            end
            REQ_VSYNC:
            begin
                if (cfg.cart_inserted && cfg.cart_autostart)
                begin
                    second_regs_next[OFS_BCTRL] = second_regs_reg[OFS_BCTRL] | FLAG_HIGH;
                    irq_lines_next[2] = second_regs_reg[OFS_BCTRL][0];
                end
                hit = (req.edge_req == EDGE_FALL && !first_regs_reg[OFS_BCTRL][1])
                    || (req.edge_req == EDGE_RISE && first_regs_reg[OFS_BCTRL][1]);
                if (hit)
                begin
                    first_regs_next[OFS_BCTRL] = first_regs_reg[OFS_BCTRL] | FLAG_HIGH;
                    if (first_regs_reg[OFS_BCTRL][0])
                    begin
                        irq_lines_next[1] = 1'b1;
                    end
                end
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        res.rdata        = rd;
        res.hsync_irq    = irq_lines_next[0];
        res.vsync_irq    = irq_lines_next[1];
        res.cart_firq    = irq_lines_next[2];
        res.column_drive = first_regs_next[OFS_BDATA] | ~first_dirs_next[1];
        res.mux_select   = {first_regs_next[OFS_BCTRL][3], first_regs_next[OFS_ACTRL][3]};
        res.motor_on     = second_regs_next[OFS_ACTRL][3];
        res.video_mode   = second_regs_next[OFS_BDATA][7:3];
        res.audio_dac    = dac_level_next;
        res.cassette_out = tape_level_next;
        res.sound_level  = {beep_bit_next, 7'b0};
        res.printer_bit  = second_regs_next[OFS_ADATA][1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                first_regs_reg[i]  <= 8'h00;
                second_regs_reg[i] <= 8'h00;
            end
            for (int i = 0; i < 2; i++)
            begin
                first_dirs_reg[i]  <= 8'h00;
                second_dirs_reg[i] <= 8'h00;
            end
            dac_level_reg  <= 7'h00;
            tape_level_reg <= 8'h00;
            beep_bit_reg   <= 1'b0;
            irq_lines_reg  <= 3'b000;
        end
        else if (adv)
        begin
            first_regs_reg  <= first_regs_next;
            first_dirs_reg  <= first_dirs_next;
            second_regs_reg <= second_regs_next;
            second_dirs_reg <= second_dirs_next;
            dac_level_reg   <= dac_level_next;
            tape_level_reg  <= tape_level_next;
            beep_bit_reg    <= beep_bit_next;
            irq_lines_reg   <= irq_lines_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dual_pia_register_block_top.sv -----
// Top level of the dual peripheral adapter register block.
// Instantiates dpia_in_stage and dpia_core; uses dpia_pkg.
//
// Usage:
//   Requests enter on the s_ channel: tuser carries the request kind (bus
//   read, bus write, horizontal sync edge, vertical sync edge), tdata the
//   address, write byte, edge polarity, keyboard rows and cassette bit.
//   Every request yields one word on the m_ channel: the read byte (zero
//   for other kinds) plus the interrupt lines and output levels after the
//   update.
//   Each word is registered first in the input register, then the update logic
//   loads the output register that drives m_tvalid. Throughput is one word per
//   cycle while the receiver does not stall; the adapter state is updated in
//   the same edge that loads the output register.
//   When the receiver stalls, the output word holds and the input register
//   still takes one more word; s_tready then drops until m_tready returns.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
//   Reset clears all adapter registers, levels and interrupt lines, sets
//   fast load and cartridge present off and cartridge autostart on.
`default_nettype none

module dual_pia_register_block_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // addr[2:0], wdata[10:3], edge_req[12:11], key_pins[20:13], cassette_in[21], zero
    input  wire logic [dpia_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  wire logic [dpia_pkg::S_USER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // rdata[7:0], hsync_irq[8], vsync_irq[9], cart_firq[10], column_drive[18:11],
    // mux_select[20:19], motor_on[21], video_mode[26:22], audio_dac[33:27],
    // cassette_out[41:34], sound_level[49:42], printer_bit[50], zero
    output logic [dpia_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [dpia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpia_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dpia_pkg::*;

    logic  adv;
    logic  out_free;
    req_t  req;
    res_t  res;
    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    dpia_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .adv      (adv),
        .req      (req)
    );

    dpia_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (req),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAST_LOAD:      cfg_next.fast_load      = cfg_wdata[0];
                CFG_CART_INSERTED:  cfg_next.cart_inserted  = cfg_wdata[0];
                CFG_CART_AUTOSTART: cfg_next.cart_autostart = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
        out_data_next = {5'b0, res.printer_bit, res.sound_level, res.cassette_out,
                         res.audio_dac, res.video_mode, res.motor_on, res.mux_select,
                         res.column_drive, res.cart_firq, res.vsync_irq,
                         res.hsync_irq, res.rdata};
        out_valid_next = adv || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{fast_load: 1'b0, cart_inserted: 1'b0, cart_autostart: 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dpia_checker.sv -----
// Port-level checks for the dual peripheral adapter register block.
// Bound to dual_pia_register_block_top; uses dpia_pkg for widths.
`default_nettype none

module dpia_port_checks (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [dpia_pkg::M_DATA_W-1:0]  m_tdata
);
    import dpia_pkg::*;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side free");

    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[48:42] == 7'd0) && (m_tdata[27] == 1'b0)
                     && (m_tdata[35:34] == 2'd0) && (m_tdata[55:51] == 5'd0))
        else $error("output level outside its value set");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !m_tvalid |=> ##1 m_tvalid)
        else $error("accepted word did not reach the output");

endmodule

bind dual_pia_register_block_top dpia_port_checks u_dpia_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/sv/dpia_checker.sv -----
`timescale 1ns / 1ps
// Checker for dual_pia_register_block_top: follows accepted requests and setting writes,
// predicts every output word and compares it field by field. Depends on dpia_pkg.
module dpia_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [dpia_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [dpia_pkg::S_USER_W-1:0]   s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [dpia_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [dpia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpia_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                   fail_count,
    output int                                   pending
);
    import dpia_pkg::*;

    logic [7:0] unit0_reg [4];
    logic [7:0] unit0_dir [2];
    logic [7:0] unit1_reg [4];
    logic [7:0] unit1_dir [2];
    logic [6:0] dac_q;
    logic [7:0] tape_q;
    logic       beep_q;
    logic [2:0] irq_q;
    cfg_t       setting;
    res_t       expected_words [$];

    function automatic logic [1:0] mux_sel();
        return {unit0_reg[OFS_BCTRL][3], unit0_reg[OFS_ACTRL][3]};
    endfunction

    task automatic flag_sync(input logic [1:0] ofs, input int line);
        unit0_reg[ofs] = unit0_reg[ofs] | FLAG_HIGH;
        if (unit0_reg[ofs][0])
            irq_q[line] = 1'b1;
    endtask

    task automatic predict_word(input req_kind_t kind, input logic [2:0] a, input logic [7:0] d,
                                input logic [1:0] e, input logic [7:0] keys, input logic cas,
                                output res_t w);
        logic [1:0] ofs;
        logic [1:0] ctl;
        logic [7:0] rd;
        ofs = a[1:0];
        ctl = {ofs[1], 1'b1};
        rd = 8'h00;
        case (kind)
            REQ_READ:
            begin
                if (!a[2])
                begin
                    if (ofs[0])
                        rd = unit0_reg[ofs];
                    else if (!unit0_reg[ctl][2])
                        rd = unit0_dir[ofs[1]];
                    else
                    begin
                        unit0_reg[ctl] = unit0_reg[ctl] & CTRL_KEEP;
                        irq_q[ofs[1]] = 1'b0;
                        rd = ofs[1] ? (unit0_reg[OFS_BDATA] & unit0_dir[1]) : keys;
                    end
                end
                else
                begin
                    if (ofs[0])
                        rd = unit1_reg[ofs];
                    else if (!unit1_reg[ctl][2])
                        rd = unit1_dir[ofs[1]];
                    else
                    begin
                        unit1_reg[ctl] = unit1_reg[ctl] & CTRL_KEEP;
                        if (ofs[1])
                        begin
                            irq_q[2] = 1'b0;
                            rd = unit1_reg[OFS_BDATA] & unit1_dir[1];
                        end
                        else if (setting.fast_load)
                            rd = {unit1_reg[OFS_ADATA][7:1], cas};
                        else
                            rd = unit1_reg[OFS_ADATA];
                    end
                end
            end
            REQ_WRITE:
            begin
                if (!a[2])
                begin
                    if (ofs[0])
                        unit0_reg[ofs] = d & CTRL_KEEP;
                    else if (unit0_reg[ctl][2])
                        unit0_reg[ofs] = d;
                    else
                        unit0_dir[ofs[1]] = d;
                end
                else if (ofs[0])
                    unit1_reg[ofs] = d & CTRL_KEEP;
                else if (!unit1_reg[ctl][2])
                    unit1_dir[ofs[1]] = d;
                else if (ofs[1])
                begin
                    unit1_reg[OFS_BDATA] = d & unit1_dir[1];
                    beep_q = unit1_reg[OFS_BDATA][1];
                end
                else
                begin
                    unit1_reg[OFS_ADATA] = d;
                    if (mux_sel() == 2'd0)
                    begin
                        if (unit1_reg[OFS_BCTRL][3])
                            dac_q = d[7:1] & 7'h7E;
                        else
                            tape_q = d & 8'hFC;
                    end
                end
            end
            REQ_HSYNC:
            begin
                if (e == EDGE_ANY || (e == EDGE_FALL && !unit0_reg[OFS_ACTRL][1])
                    || (e == EDGE_RISE && unit0_reg[OFS_ACTRL][1]))
                    flag_sync(OFS_ACTRL, 0);
            end
            default:
            begin
                if (setting.cart_inserted && setting.cart_autostart)
                begin
                    unit1_reg[OFS_BCTRL] = unit1_reg[OFS_BCTRL] | FLAG_HIGH;
                    irq_q[2] = unit1_reg[OFS_BCTRL][0];
                end
                if ((e == EDGE_FALL && !unit0_reg[OFS_BCTRL][1])
                    || (e == EDGE_RISE && unit0_reg[OFS_BCTRL][1]))
                    flag_sync(OFS_BCTRL, 1);
            end
        endcase
        w.rdata = rd;
        w.hsync_irq = irq_q[0];
        w.vsync_irq = irq_q[1];
        w.cart_firq = irq_q[2];
        w.column_drive = unit0_reg[OFS_BDATA] | ~unit0_dir[1];
        w.mux_select = mux_sel();
        w.motor_on = unit1_reg[OFS_ACTRL][3];
        w.video_mode = unit1_reg[OFS_BDATA][7:3];
        w.audio_dac = dac_q;
        w.cassette_out = tape_q;
        w.sound_level = beep_q ? 8'd128 : 8'd0;
        w.printer_bit = unit1_reg[OFS_ADATA][1];
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, actual %0d", fname, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t seen;
        if (!rst_n)
        begin
            foreach (unit0_reg[i])
            begin
                unit0_reg[i] = 8'h00;
                unit1_reg[i] = 8'h00;
            end
            foreach (unit0_dir[i])
            begin
                unit0_dir[i] = 8'h00;
                unit1_dir[i] = 8'h00;
            end
            dac_q = '0;
            tape_q = '0;
            beep_q = 1'b0;
            irq_q = '0;
            setting.fast_load = 1'b0;
            setting.cart_inserted = 1'b0;
            setting.cart_autostart = 1'b1;
            expected_words.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.rdata = m_tdata[7:0];
                seen.hsync_irq = m_tdata[8];
                seen.vsync_irq = m_tdata[9];
                seen.cart_firq = m_tdata[10];
                seen.column_drive = m_tdata[18:11];
                seen.mux_select = m_tdata[20:19];
                seen.motor_on = m_tdata[21];
                seen.video_mode = m_tdata[26:22];
                seen.audio_dac = m_tdata[33:27];
                seen.cassette_out = m_tdata[41:34];
                seen.sound_level = m_tdata[49:42];
                seen.printer_bit = m_tdata[50];
                if (expected_words.size() == 0)
                begin
                    $error("output word with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("rdata", want.rdata, seen.rdata);
                    check_field("hsync_irq", want.hsync_irq, seen.hsync_irq);
                    check_field("vsync_irq", want.vsync_irq, seen.vsync_irq);
                    check_field("cart_firq", want.cart_firq, seen.cart_firq);
                    check_field("column_drive", want.column_drive, seen.column_drive);
                    check_field("mux_select", want.mux_select, seen.mux_select);
                    check_field("motor_on", want.motor_on, seen.motor_on);
                    check_field("video_mode", want.video_mode, seen.video_mode);
                    check_field("audio_dac", want.audio_dac, seen.audio_dac);
                    check_field("cassette_out", want.cassette_out, seen.cassette_out);
                    check_field("sound_level", want.sound_level, seen.sound_level);
                    check_field("printer_bit", want.printer_bit, seen.printer_bit);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_word(req_kind_t'(s_tuser), s_tdata[2:0], s_tdata[10:3], s_tdata[12:11],
                             s_tdata[20:13], s_tdata[21], want);
                expected_words.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FAST_LOAD:      setting.fast_load = cfg_wdata[0];
                    CFG_CART_INSERTED:  setting.cart_inserted = cfg_wdata[0];
                    CFG_CART_AUTOSTART: setting.cart_autostart = cfg_wdata[0];
                    default:            ;
                endcase
            end
            pending = expected_words.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for dual_pia_register_block_top: clock, reset, request stimulus,
// setting writes and the verdict. Depends on dpia_pkg and dpia_checker.
module tb;
    import dpia_pkg::*;

    localparam logic [1:0] EDGE_NONE = 2'd3;
    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 216;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  quiet;
    logic                  hold_req;
    int                    fail_count;
    int                    pending;
    int                    stall_cycles = 0;

    dual_pia_register_block_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dpia_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready = quiet || $urandom_range(0, 99) >= 7;
        end
    end

    task automatic offer_request(input req_kind_t kind, input logic [2:0] a, input logic [7:0] d,
                                 input logic [1:0] e, input logic [7:0] keys, input logic cas);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {2'b00, cas, keys, e, d, a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_request();
        req_kind_t  kind;
        logic [2:0] a;
        logic [7:0] d;
        int         pick;
        pick = $urandom_range(0, 99);
        kind = pick < 35 ? REQ_READ : pick < 70 ? REQ_WRITE : pick < 85 ? REQ_HSYNC : REQ_VSYNC;
        a = 3'($urandom_range(0, 7));
        d = 8'($urandom);
        // favor data select on control writes so the data paths stay reachable
        if (kind == REQ_WRITE && a[0] && $urandom_range(0, 9) < 7)
            d[2] = 1'b1;
        offer_request(kind, a, d, 2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_until_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input logic fast, input logic cart, input logic autostart);
        write_setting(CFG_FAST_LOAD, fast);
        write_setting(CFG_CART_INSERTED, cart);
        write_setting(CFG_CART_AUTOSTART, autostart);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_READ;
        cfg_we = 1'b0;
        cfg_index = CFG_FAST_LOAD;
        cfg_wdata = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        apply_settings(1'b1, 1'b1, 1'b1);

        offer_request(REQ_READ, {1'b0, OFS_ADATA}, 8'h00, EDGE_FALL, 8'hFF, 1'b0);
        offer_request(REQ_WRITE, {1'b0, OFS_BDATA}, 8'hFF, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_BDATA}, 8'hFF, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_ADATA}, 8'h00, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b0, OFS_ACTRL}, 8'hFF, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b0, OFS_BCTRL}, 8'h05, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_ACTRL}, 8'h3C, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_BCTRL}, 8'h0F, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_HSYNC, 3'd0, 8'h00, EDGE_RISE, 8'h00, 1'b0);
        offer_request(REQ_HSYNC, 3'd0, 8'h00, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_HSYNC, 3'd0, 8'h00, EDGE_ANY, 8'h00, 1'b0);
        offer_request(REQ_HSYNC, 3'd0, 8'h00, EDGE_NONE, 8'h00, 1'b0);
        offer_request(REQ_VSYNC, 3'd0, 8'h00, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_VSYNC, 3'd0, 8'h00, EDGE_RISE, 8'h00, 1'b0);
        offer_request(REQ_VSYNC, 3'd0, 8'h00, EDGE_NONE, 8'h00, 1'b0);
        offer_request(REQ_READ, {1'b0, OFS_ADATA}, 8'h00, EDGE_FALL, 8'hA5, 1'b0);
        offer_request(REQ_READ, {1'b0, OFS_BDATA}, 8'h00, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_READ, {1'b1, OFS_BDATA}, 8'h00, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_ADATA}, 8'hFF, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b0, OFS_ACTRL}, 8'h04, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_ADATA}, 8'hFF, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_BCTRL}, 8'h04, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_ADATA}, 8'hFF, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_WRITE, {1'b1, OFS_BDATA}, 8'hFE, EDGE_FALL, 8'h00, 1'b0);
        offer_request(REQ_READ, {1'b1, OFS_ADATA}, 8'h00, EDGE_FALL, 8'h00, 1'b1);
        offer_request(REQ_VSYNC, 3'd0, 8'h00, EDGE_ANY, 8'h00, 1'b0);

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_until_drained();
            case (phase)
                0:       apply_settings(1'b0, 1'b0, 1'b1);
                1:       apply_settings(1'b1, 1'b1, 1'b1);
                2:       apply_settings(1'b1, 1'b1, 1'b0);
                3:       apply_settings(1'b0, 1'b1, 1'b1);
                default: apply_settings(1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            quiet = (phase == 2);
            if (phase == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                random_request();
                if (phase == 3 && n == PHASE_WORDS / 2)
                    wait_until_drained();
            end
        end

        wait_until_drained();
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
